FILE: hw/rtl/lc3_instruction_step_top_defines.svh
// Assertion macros for the instruction step core
`ifndef LC3_INSTRUCTION_STEP_TOP_DEFINES_SVH
`define LC3_INSTRUCTION_STEP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ISC_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ISC_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define ISC_ASSERT_IMPL(label, clk, rst_n, a, c)
`define ISC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hw/rtl/isc_pkg.sv
// Shared types and constants of the instruction step core
package isc_pkg;
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_EXEC = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_LOW = 4'd1;
	localparam logic [3:0] ST_HIGH = 4'd2;
	localparam logic [3:0] ST_PAD = 4'd3;
	localparam logic [3:0] ST_RTI = 4'd4;
	localparam logic [3:0] ST_OPC = 4'd5;
	localparam logic [3:0] ST_VEC = 4'd6;
	localparam logic [3:0] ST_ASCII = 4'd7;
	localparam logic [3:0] ST_UNSUP = 4'd8;

	localparam logic [0:0] REG_START = 1'd0;
	localparam logic [0:0] REG_LIMIT = 1'd1;

	localparam logic [15:0] SENT_LOW = 16'hdddd;
	localparam logic [15:0] SENT_HIGH = 16'heeee;

	// instruction opcodes, bits 15:12
	localparam logic [3:0] OPC_BR = 4'd0;
	localparam logic [3:0] OPC_ADD = 4'd1;
	localparam logic [3:0] OPC_LD = 4'd2;
	localparam logic [3:0] OPC_ST = 4'd3;
	localparam logic [3:0] OPC_JSR = 4'd4;
	localparam logic [3:0] OPC_AND = 4'd5;
	localparam logic [3:0] OPC_LDR = 4'd6;
	localparam logic [3:0] OPC_STR = 4'd7;
	localparam logic [3:0] OPC_RTI = 4'd8;
	localparam logic [3:0] OPC_NOT = 4'd9;
	localparam logic [3:0] OPC_LDI = 4'd10;
	localparam logic [3:0] OPC_STI = 4'd11;
	localparam logic [3:0] OPC_JMP = 4'd12;
	localparam logic [3:0] OPC_LEA = 4'd14;
	localparam logic [3:0] OPC_TRAP = 4'd15;

	// trap vectors
	localparam logic [7:0] TRAP_GETC = 8'h20;
	localparam logic [7:0] TRAP_OUT = 8'h21;
	localparam logic [7:0] TRAP_PUTS = 8'h22;
	localparam logic [7:0] TRAP_IN = 8'h23;
	localparam logic [7:0] TRAP_PUTSP = 8'h24;
	localparam logic [7:0] TRAP_HALT = 8'h25;

	typedef struct packed {
		logic [1:0] op;
		logic [15:0] addr;
		logic [15:0] data;
		logic [7:0] char_in;
	} in_item_t;

	typedef struct packed {
		logic [3:0] status;
		logic halted;
		logic [6:0] char_out;
		logic char_valid;
		logic [15:0] pc_now;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // latch input item
		logic exec;      // decode and execute with the fetched word
		logic finish;    // second stage of a load/store
		logic finish2;   // third stage (indirect)
	} isc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_mem;  // instruction continues with a memory access
		logic need_ind;  // a second dependent access follows
	} isc_sts_t;
endpackage

FILE: hw/rtl/isc_if.sv
// Valid/ready channel interface carrying one payload
interface isc_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: hw/rtl/isc_ctrl.sv
// Sequencer that steps one item through fetch, execute and memory phases
module isc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input isc_pkg::isc_sts_t sts,
	output isc_pkg::isc_cmd_t cmd
);
	import isc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_MEM = 3'd3;

	logic [2:0] state_q;
	logic out_valid_q;
	logic take;

	// a new item enters when the controller is idle and the result register is free or being drained
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign take = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.take = take;
		case (state_q)
			S_FETCH: cmd.exec = 1'b1;
			S_EXEC: cmd.finish = 1'b1;
			S_MEM: cmd.finish2 = 1'b1;
			default: ;
		endcase
	end

	// state sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take)
						state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (sts.need_mem)
						state_q <= S_EXEC;
					else begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				S_EXEC: begin
					if (sts.need_ind)
						state_q <= S_MEM;
					else begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				S_MEM: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/isc_dp.sv
// Datapath: register file, PC, flags, memory and instruction execution
module isc_dp #(
	parameter int MEMORY_WORDS = 65536
) (
	input logic clk,
	input logic arst_n,
	input isc_pkg::isc_cmd_t cmd,
	output isc_pkg::isc_sts_t sts,
	input isc_pkg::in_item_t in_item,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_data,
	output isc_pkg::out_item_t res
);
	import isc_pkg::*;

	localparam int AW = $clog2(MEMORY_WORDS);

	logic [15:0] mem [MEMORY_WORDS];
	logic [15:0] rdata;
	logic [15:0] rf_q [8];
	logic [15:0] pc_q, start_q, limit_q;
	logic [2:0] cc_q;
	logic halt_q;
	in_item_t it_q;
	logic [3:0] status_q;
	logic [6:0] cout_q;
	logic cval_q;
	logic is_ind_q;   // LDI/STI
	logic is_st_q;    // store kind
	logic [2:0] dr_q;

	// memory port: one address per cycle
	logic mwe;
	logic [15:0] maddr, mwdata;
	always_ff @(posedge clk) begin
		if (mwe)
			mem[maddr[AW-1:0]] <= mwdata;
		rdata <= mem[maddr[AW-1:0]];
	end

	function automatic logic [3:0] bchk(input logic [15:0] a, input logic [15:0] s,
			input logic [15:0] l);
		if (a < s) return ST_LOW;
		if (a > l) return ST_HIGH;
		return ST_OK;
	endfunction

	function automatic logic [2:0] flg(input logic [15:0] v);
		if (v[15]) return 3'b100;
		if (v == 16'd0) return 3'b010;
		return 3'b001;
	endfunction

	// decode of fetched word (rdata valid in exec cycle)
	logic [15:0] ins, pc1, off9, off6, off11, imm5, opb, alu, sra, ea;
	logic [3:0] opc, fb;
	logic [2:0] dr, sr;
	assign ins = rdata;
	assign opc = ins[15:12];
	assign dr = ins[11:9];
	assign sr = ins[8:6];
	assign pc1 = pc_q + 16'd1;
	assign off9 = {{7{ins[8]}}, ins[8:0]};
	assign off6 = {{10{ins[5]}}, ins[5:0]};
	assign off11 = {{5{ins[10]}}, ins[10:0]};
	assign imm5 = {{11{ins[4]}}, ins[4:0]};
	assign sra = rf_q[sr];
	assign opb = ins[5] ? imm5 : rf_q[ins[2:0]];
	assign alu = (opc == OPC_ADD) ? (sra + opb) : (sra & opb);
	assign ea = (opc == OPC_LDR || opc == OPC_STR) ? (sra + off6) : (pc1 + off9);
	assign fb = bchk(pc_q, start_q, limit_q);

	logic exec_ok;
	assign exec_ok = cmd.exec && (it_q.op == OP_EXEC) && !halt_q && (fb == ST_OK)
		&& (ins != SENT_LOW) && (ins != SENT_HIGH);
	logic memop;
	assign memop = (opc == OPC_LD || opc == OPC_ST || opc == OPC_LDR || opc == OPC_STR
		|| opc == OPC_LDI || opc == OPC_STI) && (bchk(ea, start_q, limit_q) == ST_OK);

	assign sts.need_mem = exec_ok && memop;
	assign sts.need_ind = cmd.finish && is_ind_q && (status_q == ST_OK)
		&& (bchk(rdata, start_q, limit_q) == ST_OK);

	// memory address selection
	always_comb begin
		mwe = 1'b0;
		maddr = pc_q;
		mwdata = rf_q[dr_q];
		if (cmd.take) begin
			maddr = (in_item.op == OP_LOAD) ? in_item.addr : pc_q;
			mwe = (in_item.op == OP_LOAD);
			mwdata = in_item.data;
		end else if (cmd.exec) begin
			maddr = ea;
			mwe = exec_ok && memop && (opc == OPC_ST || opc == OPC_STR);
			mwdata = rf_q[dr];
		end else if (cmd.finish) begin
			maddr = rdata;
			mwe = is_ind_q && is_st_q && sts.need_ind;
		end
	end

	assign res.status = status_q;
	assign res.halted = halt_q;
	assign res.char_out = cout_q;
	assign res.char_valid = cval_q;
	assign res.pc_now = pc_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 16'd12288;
			limit_q <= 16'd65023;
		end else if (cfg_we) begin
			if (cfg_index == REG_START) start_q <= cfg_data;
			else limit_q <= cfg_data;
		end
	end

	// architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) rf_q[i] <= '0;
			pc_q <= 16'd12288;
			cc_q <= '0;
			halt_q <= 1'b0;
			it_q <= '0;
			status_q <= ST_OK;
			cout_q <= '0;
			cval_q <= 1'b0;
			is_ind_q <= 1'b0;
			is_st_q <= 1'b0;
			dr_q <= '0;
		end else if (cmd.take) begin
			it_q <= in_item;
			status_q <= ST_OK;
			cout_q <= '0;
			cval_q <= 1'b0;
			is_ind_q <= 1'b0;
			if (in_item.op == OP_RESTART) begin
				for (int i = 0; i < 8; i++) rf_q[i] <= '0;
				pc_q <= start_q;
				cc_q <= '0;
				halt_q <= 1'b0;
			end
		end else if (cmd.exec) begin
			if (it_q.op == OP_EXEC && !halt_q) begin
				if (fb != ST_OK) status_q <= fb;
				else begin
					pc_q <= pc1;
					dr_q <= dr;
					is_ind_q <= (opc == OPC_LDI || opc == OPC_STI);
					is_st_q <= (opc == OPC_ST || opc == OPC_STR || opc == OPC_STI);
					if (ins == SENT_LOW) status_q <= ST_LOW;
					else if (ins == SENT_HIGH) status_q <= ST_HIGH;
					else begin
						case (opc)
							OPC_ADD, OPC_AND: begin
								if (!ins[5] && ins[4:3] != 2'd0) status_q <= ST_PAD;
								else begin
									rf_q[dr] <= alu;
									cc_q <= flg(alu);
								end
							end
							OPC_NOT: begin
								if (ins[5:0] != 6'h3f) status_q <= ST_PAD;
								else begin
									rf_q[dr] <= ~sra;
									cc_q <= flg(~sra);
								end
							end
							OPC_BR: if ((dr & cc_q) != 3'd0) pc_q <= pc1 + off9;
							OPC_JMP: begin
								if (dr != 3'd0 || ins[5:0] != 6'd0) status_q <= ST_PAD;
								else pc_q <= sra;
							end
							OPC_JSR: begin
								if (ins[11]) begin
									rf_q[7] <= pc1;
									pc_q <= pc1 + off11;
								end else if (ins[10:9] != 2'd0) status_q <= ST_PAD;
								else begin
									rf_q[7] <= pc1;
									pc_q <= sra;
								end
							end
							OPC_LD, OPC_ST, OPC_LDR, OPC_STR, OPC_LDI, OPC_STI:
								status_q <= bchk(ea, start_q, limit_q);
							OPC_LEA: rf_q[dr] <= pc1 + off9;
							OPC_TRAP: begin
								if (ins[11:8] != 4'd0) status_q <= ST_PAD;
								else begin
									case (ins[7:0])
										TRAP_GETC, TRAP_IN: rf_q[0] <= {8'd0, it_q.char_in};
										TRAP_OUT: begin
											if (rf_q[0][15:7] != 9'd0) status_q <= ST_ASCII;
											else begin
												cout_q <= rf_q[0][6:0];
												cval_q <= 1'b1;
											end
										end
										TRAP_PUTS, TRAP_PUTSP: status_q <= ST_UNSUP;
										TRAP_HALT: halt_q <= 1'b1;
										default: status_q <= ST_VEC;
									endcase
								end
							end
							OPC_RTI: status_q <= ST_RTI;
							default: status_q <= ST_OPC;
						endcase
					end
				end
			end
		end else if (cmd.finish) begin
			if (is_ind_q) begin
				if (bchk(rdata, start_q, limit_q) != ST_OK)
					status_q <= bchk(rdata, start_q, limit_q);
			end else if (!is_st_q) begin
				rf_q[dr_q] <= rdata;
				cc_q <= flg(rdata);
			end
		end else if (cmd.finish2) begin
			if (!is_st_q) begin
				rf_q[dr_q] <= rdata;
				cc_q <= flg(rdata);
			end
		end
	end
endmodule

FILE: hw/rtl/lc3_instruction_step_top.sv
// Top level of the instruction step core
// Usage: items enter on in_ch (op, addr, data, char_in); each gives exactly
// one result on out_ch (status, halted, char_out, char_valid, pc_now).
// Configuration writes on cfg (index 0 program_start, 1 user_limit) are to be
// made only while the core is idle; the core itself does not enforce this.
// Sequence: a memory load, restart, or non-memory instruction passes from
// transfer through the fetch state to the result; a load or store also
// passes the execute state, and an indirect (LDI/STI) the memory state too.
// The single synchronous memory port sets this sequence: fetch, address
// access and pointer access each take one read. One item is in work at a
// time; the next is taken while the controller is idle and the result
// register is free or being drained.
// Reset clears the registers, flags and halt, sets the PC and the bounds
// to their defaults; memory content is not cleared.
// When the receiver stalls, the result holds and no new item is taken.
module lc3_instruction_step_top #(
	parameter int MEMORY_WORDS = 65536
) (
	input logic clk,
	input logic arst_n,
	isc_if.sink in_ch,
	isc_if.source out_ch,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data
);
	import isc_pkg::*;
	`include "lc3_instruction_step_top_defines.svh"

	isc_cmd_t cmd;
	isc_sts_t sts;
	out_item_t res;

	assign cfg_ready = 1'b1;

	isc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	isc_dp #(.MEMORY_WORDS(MEMORY_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_item(in_ch.payload),
		.cfg_we(cfg_valid), .cfg_index(cfg_index[0]), .cfg_data(cfg_data),
		.res(res)
	);

	assign out_ch.payload = res;

	`ISC_ASSERT_IMPL(a_cval, clk, arst_n, out_ch.valid && !res.char_valid, res.char_out == 7'd0)
	`ISC_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, $stable(res))
	`ISC_ASSERT_IMPL(a_excl, clk, arst_n, in_ch.ready, !cmd.exec && !cmd.finish)
endmodule
